@@ hdl/psu_pkg.sv @@
`default_nettype none

package psu_pkg;

  // Geometry defaults
  localparam int MAX_WIDTH_DEF   = 4096;
  localparam int BYTES_PER_PIXEL = 4;
  localparam int HEIGHT_LIMIT    = 32768;

  // Register widths and indexes
  localparam int WIDTH_REG_W  = 13;
  localparam int HEIGHT_REG_W = 16;
  localparam int ROW_W        = 15;
  localparam int PADDR_W      = 3;
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // Filter type codes
  localparam logic [2:0] FILT_NONE  = 3'd0;
  localparam logic [2:0] FILT_SUB   = 3'd1;
  localparam logic [2:0] FILT_UP    = 3'd2;
  localparam logic [2:0] FILT_AVG   = 3'd3;
  localparam logic [2:0] FILT_PAETH = 3'd4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       image_start;
  } in_word_t;

  typedef struct packed {
    logic [7:0] pixel_byte;
    logic [1:0] channel;
    logic       row_last;
    logic       image_last;
    logic       bad_filter;
  } out_word_t;

endpackage

`default_nettype wire

@@ hdl/psu_ram.sv @@
`default_nettype none

module psu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, and registered read that holds while re is low
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hdl/psu_predict.sv @@
`default_nettype none

module psu_predict (
  input  wire logic [2:0] filter,
  input  wire logic [7:0] a,
  input  wire logic [7:0] b,
  input  wire logic [7:0] c,
  output logic      [7:0] pred
);

  logic [8:0] avg_sum;
  logic [9:0] p;
  logic [9:0] pa_ref;
  logic [9:0] pb_ref;
  logic [9:0] pc_ref;
  logic [9:0] da;
  logic [9:0] db;
  logic [9:0] dc;
  logic [7:0] paeth;

  // Paeth: compare a+b against a+c, b+c, 2c so nothing goes negative
  always_comb begin
    avg_sum = {1'b0, a} + {1'b0, b};
    p       = {2'b00, a} + {2'b00, b};
    pa_ref  = {2'b00, a} + {2'b00, c};
    pb_ref  = {2'b00, b} + {2'b00, c};
    pc_ref  = {2'b00, c} + {2'b00, c};
    da      = (p > pa_ref) ? p - pa_ref : pa_ref - p;
    db      = (p > pb_ref) ? p - pb_ref : pb_ref - p;
    dc      = (p > pc_ref) ? p - pc_ref : pc_ref - p;
    if (da <= db && da <= dc) begin
      paeth = a;
    end else if (db <= dc) begin
      paeth = b;
    end else begin
      paeth = c;
    end
  end

  // Select the predictor
  always_comb begin
    unique case (filter)
      psu_pkg::FILT_SUB:   pred = a;
      psu_pkg::FILT_UP:    pred = b;
      psu_pkg::FILT_AVG:   pred = avg_sum[8:1];
      psu_pkg::FILT_PAETH: pred = paeth;
      default:             pred = 8'd0;
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/png_scanline_unfilter.sv @@
`default_nettype none

// PNG scanline unfilter for 8-bit RGBA, non-interlaced images. Feed the
// inflated stream one word per cycle: each row is a filter-type byte followed
// by 4*width_pixels data bytes; every data byte returns one reconstructed byte
// tagged with its channel and row/image end flags, and a filter type above 4
// returns one word with bad_filter set, after which input is dropped until a
// word with image_start. The block takes one word per cycle unless a held result
// stalls it; the line store is read when a word is taken, the word is loaded
// into the reconstruct stage, and its result is registered in the output
// register, from which it is offered until taken. A held result stalls the
// input only once the reconstruct stage also holds a data or error word.
// The previous row lives in a single-port-read, single-port-write line store
// of 4*MAX_WIDTH bytes, which needs no clearing after reset. Write
// width_pixels and height_rows only while idle.
module png_scanline_unfilter #(
  parameter int MAX_WIDTH = psu_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // Input channel
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire psu_pkg::in_word_t            in_data,
  // Output channel
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output psu_pkg::out_word_t                out_data,
  // Configuration port
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [psu_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [31:0]                  pwdata,
  output logic      [31:0]                  prdata,
  output logic                              pready
);

  localparam int LINE_BYTES = psu_pkg::BYTES_PER_PIXEL * MAX_WIDTH;
  localparam int POS_W      = $clog2(LINE_BYTES);
  localparam int BPP        = psu_pkg::BYTES_PER_PIXEL;

  // Word kinds carried into the reconstruct stage
  localparam logic [1:0] K_DROP = 2'd0;
  localparam logic [1:0] K_FILT = 2'd1;
  localparam logic [1:0] K_DATA = 2'd2;
  localparam logic [1:0] K_ERR  = 2'd3;

  localparam logic [7:0] FILT_LAST = {5'd0, psu_pkg::FILT_PAETH};

  // Configuration registers
  logic [psu_pkg::WIDTH_REG_W-1:0]  width_pixels;
  logic [psu_pkg::HEIGHT_REG_W-1:0] height_rows;

  // Stream control state
  logic [POS_W-1:0]          byte_position;
  logic [psu_pkg::ROW_W-1:0] row_index;
  logic [2:0]                filter_kind;
  logic                      awaiting_filter_byte;
  logic                      error_hold;

  logic [POS_W-1:0]          byte_position_next;
  logic [psu_pkg::ROW_W-1:0] row_index_next;
  logic [2:0]                filter_kind_next;
  logic                      awaiting_filter_byte_next;
  logic                      error_hold_next;
  logic [1:0]                kind_next;
  logic                      rlast_next;
  logic                      ilast_next;

  logic [31:0] width_clamped;
  logic [31:0] height_clamped;
  logic [31:0] row_bytes;

  // Reconstruct stage
  logic             s1_valid;
  logic [1:0]       s1_kind;
  logic [POS_W-1:0] s1_pos;
  logic             s1_rlast;
  logic             s1_ilast;
  logic             s1_upper;
  logic [2:0]       s1_filter;
  logic [7:0]       s1_x;
  logic             s1_emits;
  logic             s1_go;

  logic [7:0] left_pixel       [BPP];
  logic [7:0] upper_left_pixel [BPP];

  logic [1:0] ch;
  logic [7:0] ram_q;
  logic [7:0] nb_a;
  logic [7:0] nb_b;
  logic [7:0] nb_c;
  logic [7:0] pred;
  logic [7:0] recon;

  logic accept;
  logic cfg_write;

  // Configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;
  assign prdata    = (paddr[2] == psu_pkg::REG_HEIGHT) ? {16'd0, height_rows}
                                                       : {19'd0, width_pixels};

  always_ff @(posedge clk) begin
    if (rst) begin
      width_pixels <= psu_pkg::WIDTH_REG_W'(1);
      height_rows  <= psu_pkg::HEIGHT_REG_W'(1);
    end else if (cfg_write) begin
      if (paddr[2] == psu_pkg::REG_WIDTH) begin
        width_pixels <= pwdata[psu_pkg::WIDTH_REG_W-1:0];
      end else begin
        height_rows <= pwdata[psu_pkg::HEIGHT_REG_W-1:0];
      end
    end
  end

  // Clamp geometry to the supported range
  always_comb begin
    if (width_pixels == '0) begin
      width_clamped = 32'd1;
    end else if (32'(width_pixels) > 32'(MAX_WIDTH)) begin
      width_clamped = 32'(MAX_WIDTH);
    end else begin
      width_clamped = 32'(width_pixels);
    end
    if (height_rows == '0) begin
      height_clamped = 32'd1;
    end else if (32'(height_rows) > 32'(psu_pkg::HEIGHT_LIMIT)) begin
      height_clamped = 32'(psu_pkg::HEIGHT_LIMIT);
    end else begin
      height_clamped = 32'(height_rows);
    end
    row_bytes = width_clamped << 2;
  end

  // Handshake: the reconstruct stage moves unless its result cannot be parked
  assign s1_emits  = (s1_kind == K_DATA) || (s1_kind == K_ERR);
  assign s1_go     = s1_valid && (!s1_emits || !out_valid || !out_stall);
  assign in_stall  = s1_valid && !s1_go;
  assign accept    = in_valid && !in_stall;

  // Decode the incoming word against the stream state
  always_comb begin
    error_hold_next           = error_hold;
    awaiting_filter_byte_next = awaiting_filter_byte;
    row_index_next            = row_index;
    byte_position_next        = byte_position;
    filter_kind_next          = filter_kind;
    kind_next                 = K_DROP;
    rlast_next                = 1'b0;
    ilast_next                = 1'b0;
    if (in_data.image_start) begin
      error_hold_next           = 1'b0;
      awaiting_filter_byte_next = 1'b1;
      row_index_next            = '0;
      byte_position_next        = '0;
    end
    if (!error_hold_next) begin
      if (awaiting_filter_byte_next) begin
        if (in_data.in_byte > FILT_LAST) begin
          kind_next       = K_ERR;
          error_hold_next = 1'b1;
        end else begin
          kind_next                 = K_FILT;
          filter_kind_next          = in_data.in_byte[2:0];
          awaiting_filter_byte_next = 1'b0;
          byte_position_next        = '0;
        end
      end else begin
        kind_next  = K_DATA;
        rlast_next = (32'(byte_position_next) + 32'd1) >= row_bytes;
        if (rlast_next) begin
          ilast_next                = (32'(row_index_next) + 32'd1) >= height_clamped;
          row_index_next            = ilast_next ? '0
                                                 : psu_pkg::ROW_W'(row_index_next + 1'b1);
          byte_position_next        = '0;
          awaiting_filter_byte_next = 1'b1;
        end else begin
          byte_position_next = POS_W'(byte_position_next + 1'b1);
        end
      end
    end
  end

  // Advance the stream state on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      error_hold           <= 1'b0;
      awaiting_filter_byte <= 1'b1;
      row_index            <= '0;
      byte_position        <= '0;
      filter_kind          <= psu_pkg::FILT_NONE;
    end else if (accept) begin
      error_hold           <= error_hold_next;
      awaiting_filter_byte <= awaiting_filter_byte_next;
      row_index            <= row_index_next;
      byte_position        <= byte_position_next;
      filter_kind          <= filter_kind_next;
    end
  end

  // Load the reconstruct stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind   <= kind_next;
      s1_pos    <= byte_position;
      s1_rlast  <= rlast_next;
      s1_ilast  <= ilast_next;
      s1_upper  <= (row_index != '0);
      s1_filter <= filter_kind;
      s1_x      <= in_data.in_byte;
    end
  end

  // Line store: read above byte on accept, write back the result
  psu_ram #(
    .WIDTH (8),
    .DEPTH (LINE_BYTES)
  ) u_line (
    .clk   (clk),
    .we    (s1_go && (s1_kind == K_DATA)),
    .waddr (s1_pos),
    .wdata (recon),
    .re    (accept),
    .raddr (byte_position),
    .rdata (ram_q)
  );

  // Gather neighbours; above and upper-left are zero on the first row
  assign ch   = s1_pos[1:0];
  assign nb_a = left_pixel[ch];
  assign nb_b = s1_upper ? ram_q : 8'd0;
  assign nb_c = s1_upper ? upper_left_pixel[ch] : 8'd0;

  psu_predict u_predict (
    .filter (s1_filter),
    .a      (nb_a),
    .b      (nb_b),
    .c      (nb_c),
    .pred   (pred)
  );

  assign recon = s1_x + pred;

  // Update neighbour bytes; clear them at each filter byte
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < BPP; i++) begin
        left_pixel[i]       <= 8'd0;
        upper_left_pixel[i] <= 8'd0;
      end
    end else if (s1_go) begin
      if (s1_kind == K_FILT) begin
        for (int i = 0; i < BPP; i++) begin
          left_pixel[i]       <= 8'd0;
          upper_left_pixel[i] <= 8'd0;
        end
      end else if (s1_kind == K_DATA) begin
        left_pixel[ch]       <= recon;
        upper_left_pixel[ch] <= nb_b;
      end
    end
  end

  // Output register: hold the word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_emits) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_emits) begin
      if (s1_kind == K_ERR) begin
        out_data.pixel_byte <= 8'd0;
        out_data.channel    <= 2'd0;
        out_data.row_last   <= 1'b0;
        out_data.image_last <= 1'b0;
        out_data.bad_filter <= 1'b1;
      end else begin
        out_data.pixel_byte <= recon;
        out_data.channel    <= ch;
        out_data.row_last   <= s1_rlast;
        out_data.image_last <= s1_ilast;
        out_data.bad_filter <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire
